// ===== src/b2da_pkg.sv =====
// shared constants and helper functions for the binary to decimal ascii converter
package b2da_pkg;

  localparam int DEFAULT_VALUE_WIDTH = 32;
  localparam int DECIMAL_BASE        = 10;
  localparam int BCD_W               = 4;
  localparam int CHAR_W              = 6;
  localparam int OUT_DATA_W          = 8;
  localparam int QUEUE_DEPTH         = 2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // number of decimal digits of the largest value of the given width
  function automatic int digit_count(input int w);
    logic [63:0] v;
    int          n;
    v = (w >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << w) - 64'd1);
    n = 0;
    while (v != 64'd0) begin
      v = v / DECIMAL_BASE;
      n++;
    end
    return n;
  endfunction

  // double dabble correction of one bcd digit
  function automatic logic [BCD_W-1:0] add3(input logic [BCD_W-1:0] d);
    return (d >= 4'd5) ? (d + 4'd3) : d;
  endfunction

endpackage

// ===== src/binary_to_decimal_ascii.sv =====
// top level of the binary to decimal ascii converter
// Each accepted value is sent back as its decimal digits in ASCII, most
// significant first, leading zeros dropped, zero giving a single '0', one
// digit per output transaction with tlast on the final digit. The front end
// accepts a value, runs VALUE_WIDTH shift and add-3 steps and then hands the
// bcd word to a two-entry queue; the back end takes the bcd word and steps
// through each possible digit, skipping leading zeros, with one transaction
// per printed digit. The front end takes no new value until it has handed
// the last bcd word to the queue, so with a consumer that keeps up, the
// input rate is set by the serial bcd conversion loop.
module binary_to_decimal_ascii import b2da_pkg::*; #(
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // number
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [OUT_DATA_W-1:0]                m_axis_tdata,  // digit_char, zero pad
  output logic                                 m_axis_tlast
);

  localparam int DIGITS = digit_count(VALUE_WIDTH);
  localparam int DW     = DIGITS * BCD_W;

  logic          push_valid;
  logic          push_ready;
  logic [DW-1:0] push_data;
  logic          pop_valid;
  logic          pop_ready;
  logic [DW-1:0] pop_data;

  b2da_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DIGITS      (DIGITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_value   (s_axis_tdata[VALUE_WIDTH-1:0]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  b2da_queue #(
    .WIDTH (DW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  b2da_back #(
    .DIGITS (DIGITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

// ===== src/b2da_front.sv =====
// front end: accepts a value and converts it to bcd by shift and add-3
module b2da_front import b2da_pkg::*; #(
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH,
  parameter int DIGITS      = digit_count(VALUE_WIDTH)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [VALUE_WIDTH-1:0]    in_value,
  output logic                      push_valid,
  input  logic                      push_ready,
  output logic [DIGITS*BCD_W-1:0]   push_data
);

  localparam int DW    = DIGITS * BCD_W;
  localparam int CNT_W = $clog2(VALUE_WIDTH);

  typedef enum logic [1:0] {IDLE, CONV, PUSH} state_t;

  state_t                 state;
  logic [CNT_W-1:0]       cnt;
  logic [VALUE_WIDTH-1:0] sh;
  logic [DW-1:0]          bcd;
  logic [DW-1:0]          adj;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[i*BCD_W +: BCD_W] = add3(bcd[i*BCD_W +: BCD_W]);
    end
  end

  assign in_ready   = (state == IDLE);
  assign push_valid = (state == PUSH);
  assign push_data  = bcd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            sh    <= in_value;
            bcd   <= '0;
            cnt   <= '0;
            state <= CONV;
          end
        end
        CONV: begin
          bcd <= {adj[DW-2:0], sh[VALUE_WIDTH-1]};
          sh  <= {sh[VALUE_WIDTH-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(VALUE_WIDTH - 1)) begin
            state <= PUSH;
          end
        end
        PUSH: begin
          if (push_ready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== src/b2da_queue.sv =====
// short queue of converted bcd words between front and back end
module b2da_queue import b2da_pkg::*; #(
  parameter int WIDTH = 40,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/b2da_back.sv =====
// back end: skips leading zeros and sends one ascii digit per transaction
module b2da_back import b2da_pkg::*; #(
  parameter int DIGITS = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    pop_valid,
  output logic                    pop_ready,
  input  logic [DIGITS*BCD_W-1:0] pop_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [OUT_DATA_W-1:0]   out_data,
  output logic                    out_last
);

  localparam int DW    = DIGITS * BCD_W;
  localparam int REM_W = $clog2(DIGITS);

  typedef enum logic {IDLE, RUN} state_t;

  state_t           state;
  logic [DW-1:0]    digits;
  logic [REM_W-1:0] rem;
  logic             started;
  logic [BCD_W-1:0] top;
  logic             skip;
  logic             emit;

  assign top       = digits[DW-1 -: BCD_W];
  assign pop_ready = (state == IDLE);
  assign skip      = (state == RUN) && !started && (top == '0) && (rem != '0);
  assign emit      = (state == RUN) && !skip && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      rem       <= '0;
      started   <= 1'b0;
    end else begin
      if (out_ready && !emit) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (pop_valid) begin
            digits  <= pop_data;
            rem     <= REM_W'(DIGITS - 1);
            started <= 1'b0;
            state   <= RUN;
          end
        end
        RUN: begin
          if (skip) begin
            digits <= digits << BCD_W;
            rem    <= rem - 1'b1;
          end else if (emit) begin
            out_valid <= 1'b1;
            out_data  <= {2'b00, ASCII_ZERO + {2'b00, top}};
            out_last  <= (rem == '0);
            started   <= 1'b1;
            if (rem == '0) begin
              state <= IDLE;
            end else begin
              digits <= digits << BCD_W;
              rem    <= rem - 1'b1;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== src/b2da_checker.sv =====
// port level checks for the binary to decimal ascii converter
module b2da_checker import b2da_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  logic mid_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_run <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      mid_run <= !m_axis_tlast;
    end
  end

  // output transaction holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output transaction changed while stalled");

  // every output is an ascii decimal digit
  a_digit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[7:4] == 4'h3 && m_axis_tdata[3:0] <= 4'd9)
    else $error("output is not a decimal digit");

  // front end takes one value at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a conversion runs");

  // a run never opens with a zero unless the value is zero
  a_no_lead_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !mid_run && m_axis_tdata[3:0] == 4'd0 |-> m_axis_tlast)
    else $error("leading zero not suppressed");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
